/* design/vdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vdr_pkg;

    // Table depth and the widths that follow from it.
    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 32;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } vdr_state_t;

    // One stored distinct position with the original index of its first occurrence.
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [IDX_W-1:0]      first_index;
    } vdr_entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } vdr_cmd_t;

    typedef struct packed {
        logic overflow;
        logic hit;
        logic scan_end;
        logic out_free;
    } vdr_status_t;

endpackage

`default_nettype wire

/* design/vdr_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface vdr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [vdr_pkg::COORD_BITS-1:0] pos_x;
    logic signed [vdr_pkg::COORD_BITS-1:0] pos_y;
    logic signed [vdr_pkg::COORD_BITS-1:0] pos_z;
    logic                                first_of_mesh;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output first_of_mesh, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input first_of_mesh, output ready);
endinterface

`default_nettype wire

/* design/vdr_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface vdr_out_if;
    logic                       valid;
    logic                       ready;
    logic [vdr_pkg::IDX_W-1:0] vertex_index;
    logic [vdr_pkg::IDX_W-1:0] canonical_index;
    logic [vdr_pkg::IDX_W-1:0] compact_index;
    logic                       is_unique;
    logic                       any_duplicate;
    logic                       overflow;

    modport source (output valid, output vertex_index, output canonical_index,
                    output compact_index, output is_unique, output any_duplicate,
                    output overflow, input ready);
    modport sink   (input valid, input vertex_index, input canonical_index,
                    input compact_index, input is_unique, input any_duplicate,
                    input overflow, output ready);
endinterface

`default_nettype wire

/* design/vdr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module vdr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire vdr_pkg::vdr_status_t status,
    output vdr_pkg::vdr_cmd_t         cmd
);

    vdr_pkg::vdr_state_t state_reg;
    vdr_pkg::vdr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vdr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vdr_pkg::ST_SCAN;
                end
            end
            vdr_pkg::ST_SCAN:
            begin
                if (status.overflow || status.hit || status.scan_end)
                begin
                    state_next = vdr_pkg::ST_COMMIT;
                end
            end
            vdr_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = vdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vdr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            vdr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            vdr_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            vdr_pkg::ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/vdr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module vdr_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire vdr_pkg::vdr_cmd_t                     cmd,
    output vdr_pkg::vdr_status_t                       status,
    input  wire logic signed [vdr_pkg::COORD_BITS-1:0] pos_x,
    input  wire logic signed [vdr_pkg::COORD_BITS-1:0] pos_y,
    input  wire logic signed [vdr_pkg::COORD_BITS-1:0] pos_z,
    input  wire logic                                  first_of_mesh,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic [vdr_pkg::IDX_W-1:0]                  vertex_index,
    output logic [vdr_pkg::IDX_W-1:0]                  canonical_index,
    output logic [vdr_pkg::IDX_W-1:0]                  compact_index,
    output logic                                       is_unique,
    output logic                                       any_duplicate,
    output logic                                       overflow
);

    vdr_pkg::vdr_entry_t table_mem [vdr_pkg::MAX_VERTICES];

    logic [vdr_pkg::COORD_BITS-1:0] x_reg;
    logic [vdr_pkg::COORD_BITS-1:0] y_reg;
    logic [vdr_pkg::COORD_BITS-1:0] z_reg;

    logic [vdr_pkg::CNT_W-1:0] vertex_count_reg;
    logic [vdr_pkg::CNT_W-1:0] unique_count_reg;
    logic                      dup_seen_reg;
    logic [vdr_pkg::CNT_W-1:0] scan_addr_reg;
    logic                      rd_valid_reg;
    vdr_pkg::vdr_entry_t       rd_data_reg;
    logic [vdr_pkg::IDX_W-1:0] rd_addr_reg;

    logic                      found_reg;
    logic [vdr_pkg::IDX_W-1:0] found_slot_reg;
    logic [vdr_pkg::IDX_W-1:0] found_canon_reg;

    logic                      out_valid_reg;
    logic [vdr_pkg::IDX_W-1:0] vertex_index_reg;
    logic [vdr_pkg::IDX_W-1:0] canonical_index_reg;
    logic [vdr_pkg::IDX_W-1:0] compact_index_reg;
    logic                      is_unique_reg;
    logic                      any_duplicate_reg;
    logic                      overflow_reg;

    logic                      cap_full;
    logic                      issue;
    logic                      hit;
    logic                      store_new;
    vdr_pkg::vdr_entry_t       wr_entry;

    assign cap_full  = (vertex_count_reg >= vdr_pkg::CNT_W'(vdr_pkg::MAX_VERTICES));
    assign issue     = cmd.scan && !cap_full && !hit && (scan_addr_reg < unique_count_reg);
    assign hit       = rd_valid_reg && (rd_data_reg.x == x_reg) && (rd_data_reg.y == y_reg)
                       && (rd_data_reg.z == z_reg);
    assign store_new = cmd.commit && !cap_full && !found_reg;

    assign status.overflow = cap_full;
    assign status.hit      = hit;
    assign status.scan_end = (scan_addr_reg == unique_count_reg) && !rd_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        wr_entry.x           = x_reg;
        wr_entry.y           = y_reg;
        wr_entry.z           = z_reg;
        wr_entry.first_index = vertex_count_reg[vdr_pkg::IDX_W-1:0];
    end

    // Table storage: one write port for new positions, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (store_new)
        begin
            table_mem[unique_count_reg[vdr_pkg::IDX_W-1:0]] <= wr_entry;
        end
        if (issue)
        begin
            rd_data_reg <= table_mem[scan_addr_reg[vdr_pkg::IDX_W-1:0]];
            rd_addr_reg <= scan_addr_reg[vdr_pkg::IDX_W-1:0];
        end
        if (cmd.load)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            z_reg <= pos_z;
        end
        if (cmd.scan && hit)
        begin
            found_slot_reg  <= rd_addr_reg;
            found_canon_reg <= rd_data_reg.first_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
            unique_count_reg <= '0;
            dup_seen_reg     <= 1'b0;
            scan_addr_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            found_reg        <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (cmd.load)
            begin
                scan_addr_reg <= '0;
                found_reg     <= 1'b0;
                if (first_of_mesh)
                begin
                    vertex_count_reg <= '0;
                    unique_count_reg <= '0;
                    dup_seen_reg     <= 1'b0;
                end
            end
            if (issue)
            begin
                scan_addr_reg <= scan_addr_reg + vdr_pkg::CNT_W'(1);
            end
            if (cmd.scan && hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit && !cap_full)
            begin
                vertex_count_reg <= vertex_count_reg + vdr_pkg::CNT_W'(1);
                if (found_reg)
                begin
                    dup_seen_reg <= 1'b1;
                end
            end
            if (store_new)
            begin
                unique_count_reg <= unique_count_reg + vdr_pkg::CNT_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            priority if (cap_full)
            begin
                vertex_index_reg    <= '0;
                canonical_index_reg <= '0;
                compact_index_reg   <= '0;
                is_unique_reg       <= 1'b0;
                any_duplicate_reg   <= dup_seen_reg;
                overflow_reg        <= 1'b1;
            end
            else if (found_reg)
            begin
                vertex_index_reg    <= vertex_count_reg[vdr_pkg::IDX_W-1:0];
                canonical_index_reg <= found_canon_reg;
                compact_index_reg   <= found_slot_reg;
                is_unique_reg       <= 1'b0;
                any_duplicate_reg   <= 1'b1;
                overflow_reg        <= 1'b0;
            end
            else
            begin
                vertex_index_reg    <= vertex_count_reg[vdr_pkg::IDX_W-1:0];
                canonical_index_reg <= vertex_count_reg[vdr_pkg::IDX_W-1:0];
                compact_index_reg   <= unique_count_reg[vdr_pkg::IDX_W-1:0];
                is_unique_reg       <= 1'b1;
                any_duplicate_reg   <= dup_seen_reg;
                overflow_reg        <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign vertex_index    = vertex_index_reg;
    assign canonical_index = canonical_index_reg;
    assign compact_index   = compact_index_reg;
    assign is_unique       = is_unique_reg;
    assign any_duplicate   = any_duplicate_reg;
    assign overflow        = overflow_reg;

`ifndef SYNTHESIS
    a_unique_le_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        unique_count_reg <= vertex_count_reg)
        else $error("distinct position count exceeds vertex count");

    a_commit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over an untaken beat");

    a_dup_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && found_reg && !cap_full) |=> dup_seen_reg)
        else $error("duplicate not recorded");

    a_found_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && found_reg) |-> ({1'b0, found_slot_reg} < unique_count_reg))
        else $error("match slot beyond filled part of the table");
`endif

endmodule

`default_nettype wire

/* design/vertex_dedup_remap_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Vertex welding unit. Each input beat carries one mesh vertex position (three signed
// 32-bit fixed-point coordinates) and a first-of-mesh flag that empties the table of
// distinct positions before the vertex is handled. For every vertex one result beat is
// returned with its original index, the lowest original index holding an exactly equal
// position, the position's slot in the deduplicated list (in order of first appearance),
// and flags for a new position, for any duplicate so far in the mesh, and for overflow
// when 256 vertices are already in the mesh (such a vertex is neither stored nor counted).
// The table lives in a single-port-read memory and is scanned one entry per cycle, so a
// new position is compared with every distinct position held, a matching one only up to
// the first matching slot, and an overflowing vertex is not scanned at all. A new vertex
// is accepted only when the previous one has been committed to the result register; the
// result beat may wait there while the next vertex is scanned.

module vertex_dedup_remap_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vdr_in_if.sink     vertex,
    vdr_out_if.source  result
);

    vdr_pkg::vdr_cmd_t    cmd;
    vdr_pkg::vdr_status_t status;
    logic                 in_ready;

    // The controller sequences load, table scan and commit of each vertex.
    vdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertex.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign vertex.ready = in_ready;

    // The datapath holds the table, the mesh counters and the result register.
    vdr_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pos_x           (vertex.pos_x),
        .pos_y           (vertex.pos_y),
        .pos_z           (vertex.pos_z),
        .first_of_mesh   (vertex.first_of_mesh),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .vertex_index    (result.vertex_index),
        .canonical_index (result.canonical_index),
        .compact_index   (result.compact_index),
        .is_unique       (result.is_unique),
        .any_duplicate   (result.any_duplicate),
        .overflow        (result.overflow)
    );

endmodule

`default_nettype wire
